// ===== rtl/mau_pkg.sv =====
`timescale 1ns / 1ps
package mau_pkg;

	// Operation codes carried by the op field
	localparam logic [1:0] OP_POW = 2'd0;
	localparam logic [1:0] OP_INV = 2'd1;
	localparam logic [1:0] OP_GCD = 2'd2;

	localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

	// Micro-operations issued by the controller to the datapath
	typedef enum logic [4:0] {
		UOP_NOP,
		UOP_LOAD,
		UOP_DIV_A_M,
		UOP_P_INIT,
		UOP_MUL_XA,
		UOP_MUL_AA,
		UOP_DIV_PROD,
		UOP_SET_X,
		UOP_SET_A_SHIFT,
		UOP_I_INIT,
		UOP_DIV_AB,
		UOP_I_STEP,
		UOP_I_MUL,
		UOP_I_UPD,
		UOP_DIV_BA,
		UOP_G_STEP,
		UOP_OUT_ZERO,
		UOP_OUT_X,
		UOP_OUT_INV,
		UOP_OUT_B
	} uop_t;

	// Datapath status seen by the controller
	typedef struct packed {
		logic [1:0] op;
		logic       m_zero;
		logic       m_le1;
		logic       wa_zero;
		logic       wb_zero;
		logic       wb_lsb;
		logic       div_done;
	} dp_status_t;

endpackage

// ===== rtl/mau_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle
module mau_div #(
	parameter int DW = 63
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quot,
	output logic [DW-1:0] rem
);
	localparam int CNT_W = $clog2(DW);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    quot_q;
	logic [DW-1:0]    dvs_q;
	logic [DW:0]      shifted;
	logic [DW+1:0]    diff;
	logic             borrow;

	// trial subtraction
	always_comb begin
		shifted = {rem_q, quot_q[DW-1]};
		diff    = {1'b0, shifted} - {2'b00, dvs_q};
		borrow  = diff[DW+1];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= borrow ? shifted[DW-1:0] : diff[DW-1:0];
			quot_q <= {quot_q[DW-2:0], ~borrow};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;
endmodule

// ===== rtl/mau_dp.sv =====
`timescale 1ns / 1ps
// Datapath: working registers, multiplier, shared divider, modulus register
module mau_dp #(
	parameter int WORD_BITS = 64,
	parameter int MOD_BITS  = 31
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mau_pkg::uop_t           uop,
	output mau_pkg::dp_status_t     status,
	input  logic                    cfg_we,
	input  logic [MOD_BITS-1:0]     cfg_data,
	input  logic [1:0]              op,
	input  logic [WORD_BITS-2:0]    operand_a,
	input  logic [WORD_BITS-2:0]    operand_b,
	output logic [WORD_BITS-2:0]    value
);
	localparam int W  = WORD_BITS - 1;
	localparam int DW = (W > 2 * MOD_BITS) ? W : 2 * MOD_BITS;
	localparam int CW = MOD_BITS + 2;

	logic [MOD_BITS-1:0]    mod_q;
	logic [1:0]             op_q;
	logic [DW-1:0]          wa_q;
	logic [DW-1:0]          wb_q;
	logic signed [CW-1:0]   cx_q;
	logic signed [CW-1:0]   cy_q;
	logic [MOD_BITS-1:0]    q_q;
	logic [2*MOD_BITS-1:0]  prod_q;
	logic signed [2*CW-1:0] prods_q;
	logic [W-1:0]           value_q;

	logic                   div_start;
	logic [DW-1:0]          div_dividend;
	logic [DW-1:0]          div_divisor;
	logic                   div_done;
	logic [DW-1:0]          div_quot;
	logic [DW-1:0]          div_rem;
	logic signed [CW-1:0]   inv_val;
	logic [DW-1:0]          inv_wide;
	logic [DW-1:0]          x_wide;

	// divider operand selection
	always_comb begin
		div_start    = 1'b1;
		div_dividend = '0;
		div_divisor  = '0;
		unique case (uop)
			mau_pkg::UOP_DIV_A_M: begin
				div_dividend = wa_q;
				div_divisor  = DW'(mod_q);
			end
			mau_pkg::UOP_DIV_PROD: begin
				div_dividend = DW'(prod_q);
				div_divisor  = DW'(mod_q);
			end
			mau_pkg::UOP_DIV_AB: begin
				div_dividend = wa_q;
				div_divisor  = wb_q;
			end
			mau_pkg::UOP_DIV_BA: begin
				div_dividend = wb_q;
				div_divisor  = wa_q;
			end
			default: div_start = 1'b0;
		endcase
	end

	mau_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// result formatting for inverse and power
	always_comb begin
		inv_val  = cx_q[CW-1] ? cx_q + $signed({2'b00, mod_q}) : cx_q;
		inv_wide = DW'(inv_val[MOD_BITS-1:0]);
		x_wide   = DW'(cx_q[MOD_BITS-1:0]);
	end

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MOD_BITS'(mau_pkg::MODULUS_RESET);
		end else if (cfg_we) begin
			mod_q <= cfg_data;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (uop)
			mau_pkg::UOP_LOAD: begin
				op_q <= op;
				wa_q <= DW'(operand_a);
				wb_q <= DW'(operand_b);
			end
			mau_pkg::UOP_P_INIT: begin
				wa_q <= div_rem;
				cx_q <= (mod_q == MOD_BITS'(1)) ? '0 : CW'(1);
			end
			mau_pkg::UOP_MUL_XA: prod_q <= cx_q[MOD_BITS-1:0] * wa_q[MOD_BITS-1:0];
			mau_pkg::UOP_MUL_AA: prod_q <= wa_q[MOD_BITS-1:0] * wa_q[MOD_BITS-1:0];
			mau_pkg::UOP_SET_X: cx_q <= $signed(CW'(div_rem[MOD_BITS-1:0]));
			mau_pkg::UOP_SET_A_SHIFT: begin
				wa_q <= div_rem;
				wb_q <= wb_q >> 1;
			end
			mau_pkg::UOP_I_INIT: begin
				wa_q <= DW'(mod_q);
				wb_q <= div_rem;
				cx_q <= '0;
				cy_q <= CW'(1);
			end
			mau_pkg::UOP_I_STEP: begin
				wa_q <= wb_q;
				wb_q <= div_rem;
				q_q  <= div_quot[MOD_BITS-1:0];
			end
			mau_pkg::UOP_I_MUL: prods_q <= $signed({{(CW-MOD_BITS){1'b0}}, q_q}) * cy_q;
			mau_pkg::UOP_I_UPD: begin
				cx_q <= cy_q;
				cy_q <= cx_q - prods_q[CW-1:0];
			end
			mau_pkg::UOP_G_STEP: begin
				wb_q <= wa_q;
				wa_q <= div_rem;
			end
			mau_pkg::UOP_OUT_ZERO: value_q <= '0;
			mau_pkg::UOP_OUT_X:    value_q <= x_wide[W-1:0];
			mau_pkg::UOP_OUT_INV:  value_q <= (wa_q == DW'(1)) ? inv_wide[W-1:0] : '0;
			mau_pkg::UOP_OUT_B:    value_q <= wb_q[W-1:0];
			default: ;
		endcase
	end

	// status toward the controller
	always_comb begin
		status.op       = op_q;
		status.m_zero   = (mod_q == '0);
		status.m_le1    = (mod_q <= MOD_BITS'(1));
		status.wa_zero  = (wa_q == '0);
		status.wb_zero  = (wb_q == '0);
		status.wb_lsb   = wb_q[0];
		status.div_done = div_done;
	end

	assign value = value_q;
endmodule

// ===== rtl/mau_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences micro-operations and owns both handshakes
module mau_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  mau_pkg::dp_status_t status,
	output mau_pkg::uop_t       uop
);
	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH,
		S_P_RED, S_P_LOOP, S_P_MULX, S_P_WX, S_P_SQ, S_P_MULA, S_P_WA,
		S_I_RED, S_I_LOOP, S_I_WDIV, S_I_MUL, S_I_UPD,
		S_G_LOOP, S_G_WDIV,
		S_DONE
	} state_t;

	state_t        state_q, state_d;
	mau_pkg::uop_t res_q, res_d;
	logic          out_valid_q;
	logic          emit;

	// next state and micro-op
	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		uop     = mau_pkg::UOP_NOP;
		emit    = 1'b0;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				uop     = mau_pkg::UOP_LOAD;
				state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				priority if (status.op == mau_pkg::OP_POW) begin
					if (status.m_zero) begin
						res_d = mau_pkg::UOP_OUT_ZERO; state_d = S_DONE;
					end else begin
						uop = mau_pkg::UOP_DIV_A_M; state_d = S_P_RED;
					end
				end else if (status.op == mau_pkg::OP_INV) begin
					if (status.m_le1) begin
						res_d = mau_pkg::UOP_OUT_ZERO; state_d = S_DONE;
					end else begin
						uop = mau_pkg::UOP_DIV_A_M; state_d = S_I_RED;
					end
				end else if (status.op == mau_pkg::OP_GCD) begin
					state_d = S_G_LOOP;
				end else begin
					res_d = mau_pkg::UOP_OUT_ZERO; state_d = S_DONE;
				end
			end
			S_P_RED: if (status.div_done) begin
				uop = mau_pkg::UOP_P_INIT; state_d = S_P_LOOP;
			end
			S_P_LOOP: begin
				priority if (status.wb_zero) begin
					res_d = mau_pkg::UOP_OUT_X; state_d = S_DONE;
				end else if (status.wb_lsb) begin
					uop = mau_pkg::UOP_MUL_XA; state_d = S_P_MULX;
				end else begin
					uop = mau_pkg::UOP_MUL_AA; state_d = S_P_MULA;
				end
			end
			S_P_MULX: begin
				uop = mau_pkg::UOP_DIV_PROD; state_d = S_P_WX;
			end
			S_P_WX: if (status.div_done) begin
				uop = mau_pkg::UOP_SET_X; state_d = S_P_SQ;
			end
			S_P_SQ: begin
				uop = mau_pkg::UOP_MUL_AA; state_d = S_P_MULA;
			end
			S_P_MULA: begin
				uop = mau_pkg::UOP_DIV_PROD; state_d = S_P_WA;
			end
			S_P_WA: if (status.div_done) begin
				uop = mau_pkg::UOP_SET_A_SHIFT; state_d = S_P_LOOP;
			end
			S_I_RED: if (status.div_done) begin
				uop = mau_pkg::UOP_I_INIT; state_d = S_I_LOOP;
			end
			S_I_LOOP: begin
				if (status.wb_zero) begin
					res_d = mau_pkg::UOP_OUT_INV; state_d = S_DONE;
				end else begin
					uop = mau_pkg::UOP_DIV_AB; state_d = S_I_WDIV;
				end
			end
			S_I_WDIV: if (status.div_done) begin
				uop = mau_pkg::UOP_I_STEP; state_d = S_I_MUL;
			end
			S_I_MUL: begin
				uop = mau_pkg::UOP_I_MUL; state_d = S_I_UPD;
			end
			S_I_UPD: begin
				uop = mau_pkg::UOP_I_UPD; state_d = S_I_LOOP;
			end
			S_G_LOOP: begin
				if (status.wa_zero) begin
					res_d = mau_pkg::UOP_OUT_B; state_d = S_DONE;
				end else begin
					uop = mau_pkg::UOP_DIV_BA; state_d = S_G_WDIV;
				end
			end
			S_G_WDIV: if (status.div_done) begin
				uop = mau_pkg::UOP_G_STEP; state_d = S_G_LOOP;
			end
			S_DONE: if (!out_valid_q || out_ready) begin
				uop     = res_q;
				emit    = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_q       <= mau_pkg::UOP_OUT_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
endmodule

// ===== rtl/modular_arithmetic_unit_top.sv =====
`timescale 1ns / 1ps
// Modular arithmetic unit: power, modular inverse and gcd on 63-bit operands.
// Input channel (in_valid/in_ready) carries op, operand_a, operand_b; one
// transaction yields exactly one result transaction on out_valid/out_ready.
// The cfg channel (cfg_valid/cfg_ready, always ready) writes the modulus;
// write it only while the unit is idle. Reset sets the modulus to 1e9+7.
// One item is worked at a time. Every step goes through a shared restoring
// divider of width DW (DW = max(WORD_BITS-1, 2*MOD_BITS), 63 by default);
// its result is used in the cycle after the last quotient bit is written.
// Power first reduces the base modulo the modulus, then for every exponent bit up
// to and including the top set bit runs one division (bit clear) or two
// (bit set). Inverse and gcd each run one division per Euclid step.
// in_ready is high only while the unit is idle. The finished result sits in
// an output register, so a new item is taken while it waits; if the receiver
// stalls with one result still pending, the next result waits inside the
// unit and no further item is accepted until it can be registered.
// Asynchronous reset (arst_n low) aborts any work and drops out_valid.
module modular_arithmetic_unit_top #(
	parameter int WORD_BITS = 64,
	parameter int MOD_BITS  = 31
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           op,
	input  logic [WORD_BITS-2:0] operand_a,
	input  logic [WORD_BITS-2:0] operand_b,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [WORD_BITS-2:0] value,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [MOD_BITS-1:0]  cfg_data
);
	mau_pkg::uop_t       uop;
	mau_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	mau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.uop       (uop)
	);

	mau_dp #(.WORD_BITS(WORD_BITS), .MOD_BITS(MOD_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.uop       (uop),
		.status    (status),
		.cfg_we    (cfg_valid),
		.cfg_data  (cfg_data),
		.op        (op),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.value     (value)
	);
endmodule

// ===== rtl/mau_chk.sv =====
`timescale 1ns / 1ps
// Port-level checks for the modular arithmetic unit
module mau_chk #(
	parameter int WORD_BITS = 64
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [WORD_BITS-2:0] value,
	input logic                 cfg_ready
);
	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value))
		else $error("result changed while stalled");

	// one item at a time: accepting closes the input
	a_in_close: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input open right after a transaction");

	// a new result only comes out of work in progress
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while idle");

	// config port never stalls
	a_cfg_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("cfg_ready low");
endmodule

bind modular_arithmetic_unit_top mau_chk #(.WORD_BITS(WORD_BITS)) u_mau_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.value     (value),
	.cfg_ready (cfg_ready)
);
